### rtl/core/pfac_pkg.sv
// ============================================================================
// pfac_pkg
// Shared types, format codes and channel arithmetic for the ARGB converter.
// ============================================================================
package pfac_pkg;

    typedef logic [2:0]  fmt_t;
    typedef logic [31:0] pixel_t;

    // Source format codes
    localparam fmt_t FMT_ARGB8888   = 3'd0;
    localparam fmt_t FMT_A8         = 3'd1;
    localparam fmt_t FMT_RGB888     = 3'd2;
    localparam fmt_t FMT_BGR888     = 3'd3;
    localparam fmt_t FMT_CMYK       = 3'd4;
    localparam fmt_t FMT_CMYK_ADOBE = 3'd5;

    localparam logic [7:0] OPAQUE_ALPHA = 8'hff;

    // One request held in a pipeline stage
    typedef struct packed {
        pixel_t pixel;
        logic   span_end;
    } pixel_req_t;

    // Scale a channel by a 9-bit factor and keep the top byte of the product
    function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [8:0] a);
        logic [16:0] prod;
        begin
            prod = {9'd0, c} * {8'd0, a};
            scale_chan = prod[15:8];
        end
    endfunction

    // Approximate x*k/255 with rounding up: (x*k + 255) >> 8
    function automatic logic [7:0] mul_div255(input logic [7:0] x, input logic [7:0] k);
        logic [16:0] prod;
        begin
            prod = {9'd0, x} * {9'd0, k} + 17'd255;
            mul_div255 = prod[15:8];
        end
    endfunction

endpackage

### rtl/core/pfac_convert.sv
// ============================================================================
// pfac_convert
// Combinational conversion of one source pixel to premultiplied ARGB8888.
// ============================================================================
module pfac_convert (
    input  pfac_pkg::pixel_t pixel_word,
    input  pfac_pkg::fmt_t   source_format,
    output pfac_pkg::pixel_t argb_pixel
);
    import pfac_pkg::*;

    logic [7:0] b0, b1, b2, b3;
    logic [8:0] alpha_inc;
    pixel_t     premul;
    logic [7:0] cm_c, cm_m, cm_y;
    logic [7:0] ad_c, ad_m, ad_y;

    assign b0 = pixel_word[7:0];
    assign b1 = pixel_word[15:8];
    assign b2 = pixel_word[23:16];
    assign b3 = pixel_word[31:24];

    assign alpha_inc = {1'b0, b3} + 9'd1;

    // Opaque pixels pass through untouched
    always_comb
    begin
        if (b3 == OPAQUE_ALPHA)
        begin
            premul = pixel_word;
        end
        else
        begin
            premul = {b3, scale_chan(b2, alpha_inc), scale_chan(b1, alpha_inc),
                      scale_chan(b0, alpha_inc)};
        end
    end

    assign cm_c = mul_div255(~b0, ~b3);
    assign cm_m = mul_div255(~b1, ~b3);
    assign cm_y = mul_div255(~b2, ~b3);
    assign ad_c = mul_div255(b0, b3);
    assign ad_m = mul_div255(b1, b3);
    assign ad_y = mul_div255(b2, b3);

    always_comb
    begin
        case (source_format)
            FMT_ARGB8888:   argb_pixel = premul;
            FMT_A8:         argb_pixel = {b0, 24'd0};
            FMT_RGB888:     argb_pixel = {OPAQUE_ALPHA, b0, b1, b2};
            FMT_BGR888:     argb_pixel = {OPAQUE_ALPHA, b2, b1, b0};
            FMT_CMYK:       argb_pixel = {OPAQUE_ALPHA, cm_c, cm_m, cm_y};
            FMT_CMYK_ADOBE: argb_pixel = {OPAQUE_ALPHA, ad_c, ad_m, ad_y};
            default:        argb_pixel = '0;
        endcase
    end

endmodule

### rtl/core/pixel_format_to_argb_converter_core.sv
// ============================================================================
// pixel_format_to_argb_converter_core
// Streams source pixels in and premultiplied ARGB8888 words out.
// ============================================================================
// Usage:
//   s_axis carries one source pixel per request; s_axis_tlast marks the last
//   pixel of a span. m_axis carries the converted ARGB8888 word with the span
//   marker copied to m_axis_tlast.
//   cfg_wr_en/cfg_wr_data load the source format register (reset: argb8888).
//   Write it only while no request is in flight.
//   An accepted request is held in the input register, then the conversion
//   logic feeds the output register, which drives m_axis_tvalid; a stall at
//   the output can keep the request waiting in the input register.
//   Throughput: one pixel per clock while the receiver does not stall, with a
//   single-pass conversion (three 8x9 and six 8x8 multiplies) between the two registers.
//   When the receiver stalls the output register holds its word, the input
//   register fills behind it, and then s_axis_tready drops; both registers
//   advance again in the cycle m_axis_tready returns.
//   Reset clears both stage valid flags and the format register; data
//   registers are not reset.
// ============================================================================
module pixel_format_to_argb_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: source_format
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] pixel_word
    input  logic        s_axis_tlast,   // span_end
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] argb_pixel
    output logic        m_axis_tlast    // span_end_out
);
    import pfac_pkg::*;

    fmt_t       source_format_reg;
    logic       s1_valid_reg, s1_valid_next;
    pixel_req_t s1_data_reg;
    logic       s2_valid_reg, s2_valid_next;
    pixel_req_t s2_data_reg;
    logic       s2_ready;
    logic       s1_load;
    logic       s2_load;
    pixel_t     conv_pixel;

    // Format register: written directly by the config strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= FMT_ARGB8888;
        end
        else if (cfg_wr_en)
        begin
            source_format_reg <= cfg_wr_data;
        end
    end

    // Output register is free when empty or being drained this cycle
    assign s2_ready      = !s2_valid_reg || m_axis_tready;
    // Input register is free when empty or advancing into the output register
    assign s_axis_tready = !s1_valid_reg || s2_ready;

    assign s1_load = s_axis_tvalid && s_axis_tready;
    assign s2_load = s1_valid_reg && s2_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_axis_tready)
        begin
            s1_valid_next = s_axis_tvalid;
        end
        s2_valid_next = s2_valid_reg;
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg.pixel    <= s_axis_tdata;
            s1_data_reg.span_end <= s_axis_tlast;
        end
        if (s2_load)
        begin
            s2_data_reg.pixel    <= conv_pixel;
            s2_data_reg.span_end <= s1_data_reg.span_end;
        end
    end

    pfac_convert u_convert (
        .pixel_word    (s1_data_reg.pixel),
        .source_format (source_format_reg),
        .argb_pixel    (conv_pixel)
    );

    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = s2_data_reg.pixel;
    assign m_axis_tlast  = s2_data_reg.span_end;

    // A request in the input register that may advance shows up at the output
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> m_axis_tvalid)
        else $error("input stage request lost on advance");

    // A drained output with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !s1_valid_reg) |=> !m_axis_tvalid)
        else $error("output request repeated after drain");

    // A blocked input stage holds its request
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("input stage changed while blocked");

    // Span marker follows its pixel into the output register
    a_last_copy: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> (m_axis_tlast == $past(s1_data_reg.span_end)))
        else $error("span marker not carried with pixel");

    // A8 conversion leaves the color bytes at zero
    a_a8_color: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_load && source_format_reg == FMT_A8) |=> (m_axis_tdata[23:0] == 24'd0))
        else $error("a8 conversion produced color");

endmodule

### verif/tb_pixel_format_to_argb_converter_core.sv
// ----------------------------------------------------------------------------
// tb_pixel_format_to_argb_converter_core
// Streams source pixels through the converter under every source format and
// checks each ARGB8888 word and span marker against an in-bench conversion.
// ----------------------------------------------------------------------------
import pfac_pkg::*;

typedef struct {
    pixel_t argb;
    logic   span_end;
} argb_word_t;

class argb_scoreboard;
    fmt_t       source_fmt;
    argb_word_t expected_argb_q[$];
    int         mismatches;

    function new();
        source_fmt = FMT_ARGB8888;
        mismatches = 0;
    endfunction

    // One CMYK channel; the adobe variant stores inverted ink
    function logic [7:0] ink_to_channel(logic [7:0] x, logic [7:0] k, bit adobe);
        int unsigned prod;
        if (adobe)
            prod = int'(x) * int'(k);
        else
            prod = (255 - int'(x)) * (255 - int'(k));
        return 8'((prod + 255) >> 8);
    endfunction

    function pixel_t premultiplied_argb(pixel_t w);
        logic [7:0]  b0, b1, b2, b3;
        int unsigned scale;
        b0 = w[7:0];
        b1 = w[15:8];
        b2 = w[23:16];
        b3 = w[31:24];
        case (source_fmt)
            FMT_ARGB8888:
            begin
                // Opaque pixels pass through untouched
                if (b3 == 8'hff)
                    return w;
                scale = int'(b3) + 1;
                return {b3, 8'((int'(b2) * scale) >> 8), 8'((int'(b1) * scale) >> 8),
                        8'((int'(b0) * scale) >> 8)};
            end
            FMT_A8:         return {b0, 24'd0};
            FMT_RGB888:     return {8'hff, b0, b1, b2};
            FMT_BGR888:     return {8'hff, b2, b1, b0};
            FMT_CMYK:
                return {8'hff, ink_to_channel(b0, b3, 1'b0), ink_to_channel(b1, b3, 1'b0),
                        ink_to_channel(b2, b3, 1'b0)};
            FMT_CMYK_ADOBE:
                return {8'hff, ink_to_channel(b0, b3, 1'b1), ink_to_channel(b1, b3, 1'b1),
                        ink_to_channel(b2, b3, 1'b1)};
            default:        return '0;
        endcase
    endfunction

    function void note_request(pixel_t pixel, logic span_end);
        argb_word_t word;
        word.argb     = premultiplied_argb(pixel);
        word.span_end = span_end;
        expected_argb_q.push_back(word);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %h, want %h", $time, field, got, want);
    endtask

    task check_result(pixel_t argb, logic span_end);
        argb_word_t want;
        if (expected_argb_q.size() == 0)
        begin
            report("unexpected word", argb, '0);
            return;
        end
        want = expected_argb_q.pop_front();
        if (argb !== want.argb)
            report("argb_pixel", argb, want.argb);
        if (span_end !== want.span_end)
            report("span_end_out", span_end, want.span_end);
    endtask
endclass

module tb_pixel_format_to_argb_converter_core;

    // Codes 6 and 7 select no format; the block outputs zero for them
    localparam fmt_t FMT_UNDEF_6 = 3'd6;
    localparam fmt_t FMT_UNDEF_7 = 3'd7;

    localparam int SETTLE_CYCLES = 6;       // pipeline is two deep, leave margin
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS   = 50;
    localparam int LIMIT_CYCLES  = 400000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [2:0]  cfg_wr_data   = FMT_ARGB8888;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;        // [31:0] pixel_word
    logic        s_axis_tlast  = 1'b0;      // span_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;              // [31:0] argb_pixel
    logic        m_axis_tlast;              // span_end_out

    // Idle odds in percent for each side; changed between phases
    int src_idle_pct;
    int snk_idle_pct;

    argb_scoreboard sb;

    always #2 clk = ~clk;

    pixel_format_to_argb_converter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Hard stop in case the stream hangs
    initial
    begin
        #(LIMIT_CYCLES * 4);
        $display("[pixel_format_to_argb_converter_core] ERROR");
        $finish;
    end

    // Receiver: check on each accepted word, then pick the next ready.
    // Signals are read right after the edge, before any update of this step.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Bytes lean toward 0x00 and 0xff so that opaque/transparent alpha and
    // full/empty ink come up often
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0, 1:    return 8'h00;
            2, 3:    return 8'hff;
            4:       return 8'hfe;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    endfunction

    // Offer one request and hold it until accepted. A gap, if any, drops
    // valid first; otherwise valid stays high from the previous request.
    task automatic send_pixel(input pixel_t pixel, input logic span_end);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixel;
        s_axis_tlast  <= span_end;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(pixel, span_end);
    endtask

    // Drop valid and wait until every converted word has come back
    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_argb_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Change format only with the pipeline empty
    task automatic write_source_format(input fmt_t fmt);
        drain_requests();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= fmt;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.source_fmt = fmt;
    endtask

    // Corner pixels for each format
    task automatic run_directed();
        write_source_format(FMT_ARGB8888);
        send_pixel(32'h00ffffff, 1'b0);     // transparent: colour scales to zero
        send_pixel(32'hffabcdef, 1'b0);     // opaque: pass through
        send_pixel(32'h80ff80ff, 1'b0);
        send_pixel(32'hfe010203, 1'b1);
        write_source_format(FMT_A8);
        send_pixel(32'hffffffff, 1'b0);
        send_pixel(32'hffffff00, 1'b1);     // upper bytes ignored
        write_source_format(FMT_RGB888);
        send_pixel(32'hff123456, 1'b0);
        send_pixel(32'h00ffffff, 1'b1);
        write_source_format(FMT_BGR888);
        send_pixel(32'h00abcdef, 1'b0);
        send_pixel(32'hffffff00, 1'b1);
        write_source_format(FMT_CMYK);
        send_pixel(32'h00000000, 1'b0);     // no ink: white
        send_pixel(32'hffffffff, 1'b0);     // full key: black
        send_pixel(32'h00ff00ff, 1'b1);
        write_source_format(FMT_CMYK_ADOBE);
        send_pixel(32'hffffffff, 1'b0);
        send_pixel(32'h00ffffff, 1'b0);     // zero key
        send_pixel(32'h80408001, 1'b1);
        write_source_format(FMT_UNDEF_6);
        send_pixel(32'hffffffff, 1'b1);
        write_source_format(FMT_UNDEF_7);
        send_pixel(32'h12345678, 1'b1);
    endtask

    initial
    begin
        fmt_t fmt_order [8];
        int   phase;
        int   n;
        fmt_order = '{FMT_ARGB8888, FMT_A8, FMT_RGB888, FMT_BGR888,
                      FMT_CMYK, FMT_CMYK_ADOBE, FMT_UNDEF_6, FMT_UNDEF_7};
        sb = new();
        src_idle_pct = 26;
        snk_idle_pct = 66;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Random phases: each format once in order, then random formats
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 5)
            begin
                src_idle_pct = 66;
                snk_idle_pct = 26;
            end
            if (phase == 9)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (phase < 8)
                write_source_format(fmt_order[phase]);
            else
                write_source_format(fmt_order[$urandom_range(7)]);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold off mid-phase now and then until the pipe runs dry
                if (n == PHASE_ITEMS / 2 && phase % 4 == 1)
                    drain_requests();
                send_pixel(random_pixel(), $urandom_range(7) == 0);
            end
        end

        drain_requests();
        if (sb.mismatches == 0 && sb.expected_argb_q.size() == 0)
            $display("[pixel_format_to_argb_converter_core] OK");
        else
            $display("[pixel_format_to_argb_converter_core] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pfac_pkg.sv
rtl/core/pfac_convert.sv
rtl/core/pixel_format_to_argb_converter_core.sv
verif/tb_pixel_format_to_argb_converter_core.sv
